// File: hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared command codes, status codes and control/status bundles for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_TRAVERSE   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    trav_start;
        logic    trav_step;
        logic    rd_back;
        logic    rd_trav;
        logic    out_load;
        logic    out_from_ram;
        t_status out_status;
        logic    out_last;
    } t_ctrl;

    // Status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic trav_last;
    } t_dstat;

endpackage

// File: hdl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed values kept in a ring buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries a command i_func and a value
//   i_push_value: push front, push back, pop front, pop back or traverse.
//   Output channel (o_valid / i_ready) returns o_item_value, o_status and
//   o_last_of_run; the final result of each command has o_last_of_run set.
//   Pushes and all error results (push on full, pop or traverse on empty)
//   appear in the cycle after acceptance. A pop result passes through the
//   single registered RAM read port, then the output register. A traverse
//   of N elements yields N results along that path, one per cycle while the
//   receiver takes them. Unused command codes are dropped.
//   One command is worked on at a time; the next is taken once the last
//   result of the current one is in the output register and that register
//   is empty or being taken, so a push can follow a push every cycle.
//   A stalled receiver holds the output register and pauses a traversal.
//   Reset empties the queue (head and count cleared) and drops any pending
//   result; slot contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [VALUE_BITS-1:0] i_push_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VALUE_BITS-1:0] o_item_value,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_last_of_run
);

    t_ctrl  s_ctl;
    t_dstat s_stat;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_func      (i_func),
        .i_out_ready (i_ready),
        .i_stat      (s_stat),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_ctl       (s_ctl)
    );

    deq_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (s_ctl),
        .i_push_value  (i_push_value),
        .o_stat        (s_stat),
        .o_item_value  (o_item_value),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!o_valid || i_ready))
        else $error("input taken while output register is blocked");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_item_value == '0 && o_last_of_run))
        else $error("error result with data or without last mark");

    a_empty_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && s_stat.count_zero &&
         (i_func == CMD_POP_FRONT || i_func == CMD_POP_BACK || i_func == CMD_TRAVERSE))
        |=> (o_valid && o_status == ST_EMPTY && o_last_of_run))
        else $error("empty queue read did not report empty");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.count_full |-> !(s_ctl.push_front || s_ctl.push_back))
        else $error("push issued on a full queue");
`endif

endmodule

// File: hdl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: decodes the input beat, steps pops and traversals and
// owns the output valid flag.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    input  logic              i_out_ready,
    input  t_dstat            i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output t_ctrl             o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_TRAV
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;
    t_ctrl  ctl;

    assign out_free   = !r_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;

    always_comb begin
        ctl            = '0;
        ctl.out_status = ST_OK;
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    unique case (i_func) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                            ctl.out_load = 1'b1;
                            ctl.out_last = 1'b1;
                            if (i_stat.count_full) begin
                                ctl.out_status = ST_FULL;
                            end else begin
                                ctl.push_front = (i_func == CMD_PUSH_FRONT);
                                ctl.push_back  = (i_func == CMD_PUSH_BACK);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (i_stat.count_zero) begin
                                ctl.out_load   = 1'b1;
                                ctl.out_last   = 1'b1;
                                ctl.out_status = ST_EMPTY;
                            end else begin
                                ctl.pop_front = (i_func == CMD_POP_FRONT);
                                ctl.pop_back  = (i_func == CMD_POP_BACK);
                                ctl.rd_back   = (i_func == CMD_POP_BACK);
                                n_state       = S_POP;
                            end
                        end
                        CMD_TRAVERSE: begin
                            if (i_stat.count_zero) begin
                                ctl.out_load   = 1'b1;
                                ctl.out_last   = 1'b1;
                                ctl.out_status = ST_EMPTY;
                            end else begin
                                ctl.trav_start = 1'b1;
                                ctl.rd_trav    = 1'b1;
                                n_state        = S_TRAV;
                            end
                        end
                        default: ;  // unused codes: drop the beat
                    endcase
                end
            end
            S_POP: begin
                // read data from the accept edge is now available
                ctl.out_load     = 1'b1;
                ctl.out_from_ram = 1'b1;
                ctl.out_last     = 1'b1;
                n_state          = S_IDLE;
            end
            S_TRAV: begin
                // keep reading the current element while the output stalls
                ctl.rd_trav = 1'b1;
                if (out_free) begin
                    ctl.out_load     = 1'b1;
                    ctl.out_from_ram = 1'b1;
                    ctl.out_last     = i_stat.trav_last;
                    if (i_stat.trav_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ctl.trav_step = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (ctl.out_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;
    assign o_ctl       = ctl;

endmodule

// File: hdl/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// Ring-buffer datapath: head index, element count, traversal index, slot
// RAM and the output payload registers.
// ----------------------------------------------------------------------------
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctl,
    input  logic [VALUE_BITS-1:0] i_push_value,
    output t_dstat                o_stat,
    output logic [VALUE_BITS-1:0] o_item_value,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_last_of_run
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    // (a + b) mod DEPTH for a, b below DEPTH
    function automatic logic [IDX_W-1:0] f_ring(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b
    );
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      head_dec;
    logic [IDX_W-1:0]      waddr, raddr, rd_ofs;
    logic                  we;
    logic [VALUE_BITS-1:0] rdata;
    logic [VALUE_BITS-1:0] r_item;
    t_status               r_status;
    logic                  r_last;

    assign head_dec = (r_head == '0) ? LAST_SLOT : r_head - IDX_W'(1);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctl.push_front) begin
            n_head  = head_dec;
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.push_back) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop_front) begin
            n_head  = f_ring(r_head, IDX_W'(1));
            n_count = r_count - CNT_W'(1);
        end else if (i_ctl.pop_back) begin
            n_count = r_count - CNT_W'(1);
        end

        if (i_ctl.trav_start) begin
            n_idx = '0;
        end else if (i_ctl.trav_step) begin
            n_idx = r_idx + IDX_W'(1);
        end else begin
            n_idx = r_idx;
        end

        // read the slot the next cycle's output will need
        if (i_ctl.rd_trav) begin
            rd_ofs = n_idx;
        end else if (i_ctl.rd_back) begin
            rd_ofs = IDX_W'(r_count - CNT_W'(1));
        end else begin
            rd_ofs = '0;
        end
    end

    assign raddr = f_ring(r_head, rd_ofs);
    assign we    = i_ctl.push_front || i_ctl.push_back;
    assign waddr = i_ctl.push_front ? head_dec : f_ring(r_head, IDX_W'(r_count));

    deq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_push_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_item   <= i_ctl.out_from_ram ? rdata : '0;
            r_status <= i_ctl.out_status;
            r_last   <= i_ctl.out_last;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == FULL_CNT);
    assign o_stat.trav_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign o_item_value  = r_item;
    assign o_status      = r_status;
    assign o_last_of_run = r_last;

endmodule

// File: tb/double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the ring-buffer deque. A directed opening covers
// empty and full errors, both ends, value extremes and the spare command
// codes; a random part alternates filling and draining phases. Every accepted
// command is run through a local copy of the deque, and each output beat is
// checked field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
    import deq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH            = 16;
    localparam int VALUE_BITS       = 32;
    localparam int CLK_PERIOD       = 12;
    localparam int RANDOM_ITEMS     = 200;
    localparam int DRAIN_AT         = 120;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CALM_TAIL        = 40;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 400000;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]     func;
        logic [VALUE_BITS-1:0] value;
        bit                    wait_idle;
    } t_deque_cmd;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        t_status               status;
        logic                  last;
    } t_deque_beat;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [FUNC_W-1:0]     i_func       = '0;
    logic [VALUE_BITS-1:0] i_push_value = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [VALUE_BITS-1:0] o_item_value;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_last_of_run;

    t_deque_cmd  cmd_q[$];
    t_deque_beat beat_q[$];

    // shadow deque
    logic [VALUE_BITS-1:0] slot_copy [DEPTH];
    int front_idx  = 0;
    int fill_count = 0;

    int  total_cmds  = 0;
    int  cmds_taken  = 0;
    int  err_count   = 0;
    int  cycle_count = 0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    bit  long_hold_done = 1'b0;
    logic in_taken = 1'b0;
    logic calm;

    assign calm = (cmds_taken + CALM_TAIL >= total_cmds);

    double_ended_queue_top #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_item_value  (o_item_value),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void queue_beat(logic [VALUE_BITS-1:0] value, t_status status,
                                       logic last);
        t_deque_beat b;
        b.value  = value;
        b.status = status;
        b.last   = last;
        beat_q.push_back(b);
    endfunction

    // Apply one command to the shadow deque and queue the beats it yields.
    function automatic void run_deque_cmd(logic [FUNC_W-1:0] func,
                                          logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] taken;
        case (func)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (fill_count == DEPTH) begin
                    queue_beat('0, ST_FULL, 1'b1);
                end else begin
                    if (func == CMD_PUSH_FRONT) begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        slot_copy[front_idx] = value;
                    end else begin
                        slot_copy[(front_idx + fill_count) % DEPTH] = value;
                    end
                    fill_count++;
                    queue_beat('0, ST_OK, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (fill_count == 0) begin
                    queue_beat('0, ST_EMPTY, 1'b1);
                end else begin
                    if (func == CMD_POP_FRONT) begin
                        taken = slot_copy[front_idx];
                        front_idx = (front_idx + 1) % DEPTH;
                    end else begin
                        taken = slot_copy[(front_idx + fill_count - 1) % DEPTH];
                    end
                    fill_count--;
                    queue_beat(taken, ST_OK, 1'b1);
                end
            end
            CMD_TRAVERSE: begin
                if (fill_count == 0) begin
                    queue_beat('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < fill_count; i++)
                        queue_beat(slot_copy[(front_idx + i) % DEPTH], ST_OK,
                                   i == fill_count - 1);
                end
            end
            default: ;  // spare codes: dropped
        endcase
    endfunction

    task automatic queue_cmd(logic [FUNC_W-1:0] func, logic [VALUE_BITS-1:0] value,
                             bit wait_idle);
        t_deque_cmd c;
        c.func      = func;
        c.value     = value;
        c.wait_idle = wait_idle;
        cmd_q.push_back(c);
        total_cmds++;
    endtask

    // Driver: hold the beat until taken, then insert a gap or offer the next one.
    always @(negedge i_clk) begin : driver
        t_deque_cmd c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold
        end else if (gap_left > 0) begin
            gap_left--;
            i_valid <= 1'b0;
        end else if (cmd_q.size() == 0 || (cmd_q[0].wait_idle && beat_q.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            c = cmd_q.pop_front();
            i_func       <= c.func;
            i_push_value <= c.value;
            i_valid      <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 15);
        end
    end

    // Receiver: random stall bursts plus one long hold-off.
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!long_hold_done && cmds_taken >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted commands, check accepted result beats.
    always @(posedge i_clk) begin : monitor
        t_deque_beat want;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (beat_q.size() == 0) begin
                    $error("unexpected result beat: item_value %0d status %0d last %0d",
                           $signed(o_item_value), o_status, o_last_of_run);
                    err_count++;
                end else begin
                    want = beat_q.pop_front();
                    if (o_item_value !== want.value) begin
                        $error("item_value: expected %0d, got %0d",
                               $signed(want.value), $signed(o_item_value));
                        err_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        err_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last, o_last_of_run);
                        err_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                run_deque_cmd(i_func, i_push_value);
                cmds_taken++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("double_ended_queue_top_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FUNC_W-1:0]     func;
        logic [VALUE_BITS-1:0] value;
        bit fill_mode;
        int phase_left;
        int roll;

        // empty errors, both ends, extremes, spare codes
        queue_cmd(CMD_TRAVERSE, '0, 1'b0);
        queue_cmd(CMD_POP_FRONT, '0, 1'b0);
        queue_cmd(CMD_POP_BACK, '0, 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
        queue_cmd(CMD_PUSH_BACK, 32'h8000_0000, 1'b0);
        queue_cmd(CMD_PUSH_FRONT, 32'h0000_0000, 1'b0);
        queue_cmd(CMD_PUSH_BACK, 32'hffff_ffff, 1'b0);
        queue_cmd(CMD_TRAVERSE, '0, 1'b0);
        queue_cmd(CMD_POP_BACK, $urandom(), 1'b0);
        queue_cmd(CMD_POP_FRONT, $urandom(), 1'b0);
        for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
            queue_cmd(f[FUNC_W-1:0], $urandom(), 1'b0);
        // fill to the brim, then overflow and walk all slots
        for (int i = 0; i < DEPTH - 2; i++)
            queue_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom(), 1'b0);
        queue_cmd(CMD_PUSH_BACK, $urandom(), 1'b0);
        queue_cmd(CMD_TRAVERSE, '0, 1'b0);

        // alternate draining and filling phases so both limits recur
        fill_mode  = 1'b0;
        phase_left = $urandom_range(10, 30);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                fill_mode  = !fill_mode;
                phase_left = $urandom_range(10, 30);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
            else if (roll < 11)
                func = CMD_TRAVERSE;
            else if ((roll < 80) == fill_mode)
                func = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            else
                func = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h7fff_ffff;
                    1:       value = 32'h8000_0000;
                    2:       value = 32'h0000_0000;
                    default: value = 32'hffff_ffff;
                endcase
            end else begin
                value = $urandom();
            end
            queue_cmd(func, value, n == DRAIN_AT);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken < total_cmds || beat_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("double_ended_queue_top_tb passed");
        else
            $display("double_ended_queue_top_tb failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/deq_dp.sv
hdl/double_ended_queue_top.sv
tb/double_ended_queue_top_tb.sv
